[rtl/core/mme_pkg.sv]
// Shared types and constants for the matrix multiply engine.
// Depends on nothing; imported by mme_cell and matrix_multiply_engine.
`timescale 1ns / 1ps
package mme_pkg;

   // Default build sizes
   localparam int MAX_DIM_DEF    = 8;
   localparam int ELEM_WIDTH_DEF = 16;

   // Field widths of the ports
   localparam int FUNC_W  = 2;
   localparam int POS_W   = 3;
   localparam int VALUE_W = 16;
   localparam int SUM_W   = 32;
   localparam int DIM_W   = 4;
   localparam int CSR_W   = 2;

   // Operation codes of an item
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_LEFT  = 2'd0,
      FUNC_LOAD_RIGHT = 2'd1,
      FUNC_START      = 2'd2,
      FUNC_UNUSED     = 2'd3
   } func_type;

   // Configuration register indexes
   typedef enum logic [CSR_W-1:0] {
      CSR_NUM_ROWS  = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_NUM_COLS  = 2'd2,
      CSR_NONE      = 2'd3
   } csr_index_type;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   // Token handed along the chain of cells
   typedef struct packed {
      logic valid;
      logic ends;
   } tok_ctl_type;

endpackage

[rtl/core/mme_cell.sv]
// One column cell: holds a column of the right matrix and one accumulator.
// Depends on mme_pkg; instantiated in a chain by matrix_multiply_engine.
`timescale 1ns / 1ps
module mme_cell #(
   parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF,
   localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int ACC_W     = 2 * ELEM_WIDTH + $clog2(MAX_DIM + 1) + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_row,
   input  logic signed [ELEM_WIDTH-1:0]  wr_data,
   input  mme_pkg::tok_ctl_type          in_ctl,
   input  logic [IDX_W-1:0]              in_k,
   input  logic signed [ELEM_WIDTH-1:0]  in_a,
   output mme_pkg::tok_ctl_type          out_ctl,
   output logic [IDX_W-1:0]              out_k,
   output logic signed [ELEM_WIDTH-1:0]  out_a,
   output logic signed [ACC_W-1:0]       acc
);
   import mme_pkg::*;

   logic signed [ELEM_WIDTH-1:0]   col_ff [MAX_DIM];
   tok_ctl_type                    ctl_ff;
   logic [IDX_W-1:0]               k_ff;
   logic signed [ELEM_WIDTH-1:0]   a_ff;
   logic                           pvalid_ff;
   logic signed [2*ELEM_WIDTH-1:0] prod_ff;
   logic signed [2*ELEM_WIDTH-1:0] prod_in;
   logic signed [ACC_W-1:0]        acc_ff;

   // Write one element of this column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         col_ff[wr_row] <= wr_data;
      end
   end

   assign prod_in = in_a * col_ff[in_k];

   // Pass the token on and register the product
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= '0;
         pvalid_ff <= 1'b0;
      end else begin
         ctl_ff    <= in_ctl;
         pvalid_ff <= in_ctl.valid;
      end
      k_ff    <= in_k;
      a_ff    <= in_a;
      prod_ff <= prod_in;
   end

   // Accumulate the products of one dot product
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         acc_ff <= '0;
      end else if (pvalid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign out_ctl = ctl_ff;
   assign out_k   = k_ff;
   assign out_a   = a_ff;
   assign acc     = acc_ff;

endmodule

[rtl/core/matrix_multiply_engine.sv]
// Top level of the matrix multiply engine: stores, sequencer, output stage.
// Depends on mme_pkg and mme_cell.
//
//   channel  ports                      handshake
//   -------  -------------------------  -------------------------------
//   request  start, busy, req_*         taken when start and not busy
//   result   rsp_valid, rsp_*           valid strobe, no stall
//   config   csr_valid/ready/index/data written when valid and ready
//
// A load item writes one store element if its indexes are in range. A start
// item, for each result row, reads the left store along the inner dimension,
// lets the token cross the chain of cells and drain, and outputs the columns.
// Reset is synchronous; config registers return to 8, store contents are undefined.
// Results cannot be stalled; busy holds off new items during a run.
`timescale 1ns / 1ps
module matrix_multiply_engine #(
   parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mme_pkg::FUNC_W-1:0]    req_func,
   input  logic [mme_pkg::POS_W-1:0]     req_row_index,
   input  logic [mme_pkg::POS_W-1:0]     req_col_index,
   input  logic signed [mme_pkg::VALUE_W-1:0] req_elem_value,
   output logic                          rsp_valid,
   output logic [mme_pkg::POS_W-1:0]     rsp_out_row,
   output logic [mme_pkg::POS_W-1:0]     rsp_out_col,
   output logic signed [mme_pkg::SUM_W-1:0] rsp_sum_value,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mme_pkg::CSR_W-1:0]     csr_index,
   input  logic [mme_pkg::DIM_W-1:0]     csr_data
);
   import mme_pkg::*;

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int DRN    = MAX_DIM + 3;
   localparam int DRN_W  = $clog2(DRN + 1);
   localparam int ACC_W  = 2 * ELEM_WIDTH + $clog2(MAX_DIM + 1) + 1;
   localparam int WIDE_W = ((ACC_W > SUM_W) ? ACC_W : SUM_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                    state_ff;
   logic [DIM_W-1:0]             rows_reg_ff, mid_reg_ff, cols_reg_ff;
   logic [CNT_W-1:0]             rows_ff, mid_ff, cols_ff;
   logic [CNT_W-1:0]             row_ff, k_ff, col_ff;
   logic [DRN_W-1:0]             drain_ff;
   logic                         clear_ff;
   logic                         rsp_valid_ff, rsp_last_ff;
   logic [POS_W-1:0]             rsp_row_ff, rsp_col_ff;
   logic signed [SUM_W-1:0]      rsp_sum_ff;

   logic signed [ELEM_WIDTH-1:0] left_mem [DEPTH];
   logic signed [ELEM_WIDTH-1:0] left_q_ff;
   tok_ctl_type                  tok_ctl_ff;
   logic [IDX_W-1:0]             tok_k_ff;

   logic                         take;
   func_type                     func;
   logic                         in_range;
   logic [ELEM_WIDTH+VALUE_W-1:0] elem_ext;
   logic signed [ELEM_WIDTH-1:0] elem;
   logic [ADDR_W-1:0]            load_addr, rd_addr;
   logic [CNT_W-1:0]             rows_eff, mid_eff, cols_eff;

   tok_ctl_type                  ctl_w [MAX_DIM+1];
   logic [IDX_W-1:0]             k_w   [MAX_DIM+1];
   logic signed [ELEM_WIDTH-1:0] a_w   [MAX_DIM+1];
   logic signed [ACC_W-1:0]      acc_w [MAX_DIM];

   logic signed [ACC_W-1:0]      acc_sel;
   logic signed [WIDE_W-1:0]     acc_wide;
   logic signed [SUM_W-1:0]      sum_sat;

   // Decode the item
   assign take      = start && !busy;
   assign func      = func_type'(req_func);
   assign in_range  = ({1'b0, req_row_index} < (POS_W+1)'(MAX_DIM)) &&
                      ({1'b0, req_col_index} < (POS_W+1)'(MAX_DIM));
   assign elem_ext  = {{ELEM_WIDTH{1'b0}}, req_elem_value};
   assign elem      = elem_ext[ELEM_WIDTH-1:0];
   assign load_addr = ADDR_W'(int'(req_row_index) * MAX_DIM + int'(req_col_index));
   assign rd_addr   = ADDR_W'(int'(row_ff) * MAX_DIM + int'(k_ff));

   // Clamp the dimensions to the array size
   assign rows_eff = (rows_reg_ff > DIM_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(rows_reg_ff);
   assign mid_eff  = (mid_reg_ff  > DIM_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(mid_reg_ff);
   assign cols_eff = (cols_reg_ff > DIM_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(cols_reg_ff);

   // Configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff <= DIM_RESET;
         mid_reg_ff  <= DIM_RESET;
         cols_reg_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_ROWS:  rows_reg_ff <= csr_data;
            CSR_INNER_DIM: mid_reg_ff  <= csr_data;
            CSR_NUM_COLS:  cols_reg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Left store: written by loads, read one element a cycle while feeding
   always_ff @(posedge clock) begin
      if (take && func == FUNC_LOAD_LEFT && in_range) begin
         left_mem[load_addr] <= elem;
      end
      left_q_ff <= left_mem[rd_addr];
   end

   // Token entering the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ctl_ff <= '0;
      end else begin
         tok_ctl_ff.valid <= (state_ff == ST_FEED);
         tok_ctl_ff.ends  <= (state_ff == ST_FEED) && (k_ff == mid_ff - 1'b1);
      end
      tok_k_ff <= k_ff[IDX_W-1:0];
   end

   assign ctl_w[0] = tok_ctl_ff;
   assign k_w[0]   = tok_k_ff;
   assign a_w[0]   = left_q_ff;

   // Chain of column cells
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      mme_cell #(
         .MAX_DIM    (MAX_DIM),
         .ELEM_WIDTH (ELEM_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (clear_ff),
         .wr_en   (take && func == FUNC_LOAD_RIGHT && in_range &&
                   (int'(req_col_index) == j)),
         .wr_row  (req_row_index[IDX_W-1:0]),
         .wr_data (elem),
         .in_ctl  (ctl_w[j]),
         .in_k    (k_w[j]),
         .in_a    (a_w[j]),
         .out_ctl (ctl_w[j+1]),
         .out_k   (k_w[j+1]),
         .out_a   (a_w[j+1]),
         .acc     (acc_w[j])
      );
   end

   // Select the column being emitted and saturate it
   assign acc_sel  = acc_w[col_ff[IDX_W-1:0]];
   assign acc_wide = WIDE_W'(acc_sel);
   always_comb begin
      priority if (acc_wide > $signed({{(WIDE_W-SUM_W){1'b0}}, 1'b0, {(SUM_W-1){1'b1}}})) begin
         sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (acc_wide < $signed({{(WIDE_W-SUM_W){1'b1}}, 1'b1, {(SUM_W-1){1'b0}}})) begin
         sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sum_sat = acc_wide[SUM_W-1:0];
      end
   end

   // Sequencer: feed a row, drain the chain, emit its columns
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clear_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         clear_ff     <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (take && func == FUNC_START &&
                   rows_eff != '0 && cols_eff != '0) begin
                  rows_ff  <= rows_eff;
                  mid_ff   <= mid_eff;
                  cols_ff  <= cols_eff;
                  row_ff   <= '0;
                  k_ff     <= '0;
                  drain_ff <= '0;
                  clear_ff <= 1'b1;
                  state_ff <= (mid_eff == '0) ? ST_DRAIN : ST_FEED;
               end
            end
            ST_FEED: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == mid_ff - 1'b1) begin
                  drain_ff <= '0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (drain_ff == DRN_W'(DRN)) begin
                  col_ff   <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_row_ff   <= POS_W'(row_ff);
               rsp_col_ff   <= POS_W'(col_ff);
               rsp_sum_ff   <= sum_sat;
               rsp_last_ff  <= (col_ff == cols_ff - 1'b1) && (row_ff == rows_ff - 1'b1);
               col_ff       <= col_ff + 1'b1;
               if (col_ff == cols_ff - 1'b1) begin
                  if (row_ff == rows_ff - 1'b1) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff   <= row_ff + 1'b1;
                     k_ff     <= '0;
                     drain_ff <= '0;
                     clear_ff <= 1'b1;
                     state_ff <= (mid_ff == '0) ? ST_DRAIN : ST_FEED;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_sum_value = rsp_sum_ff;
   assign rsp_last      = rsp_valid_ff && rsp_last_ff;

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result strobe without an emit cycle");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> !busy)
      else $error("engine still busy on the last result");
   a_clear_before_feed: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !tok_ctl_ff.valid)
      else $error("accumulator clear while a token enters the chain");
   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && $past(state_ff == ST_DRAIN) |->
      $past(drain_ff == DRN_W'(DRN)))
      else $error("emit started before the chain drained");
`endif

endmodule

[test/matrix_multiply_engine_test.sv]
// Self-checking testbench for the matrix multiply engine: loads matrices,
// runs multiplies under several dimension settings and idle patterns.
// Depends on mme_pkg and the matrix_multiply_engine RTL.
`timescale 1ns / 1ps
module matrix_multiply_engine_test;
   import mme_pkg::*;

   localparam int DIM      = MAX_DIM_DEF;
   localparam int DRAIN    = 300;
   localparam int MAX_SHOW = 10;

   typedef struct {
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } product_entry_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   func_type                  req_func = FUNC_LOAD_LEFT;
   logic [POS_W-1:0]          req_row_index = '0;
   logic [POS_W-1:0]          req_col_index = '0;
   logic signed [VALUE_W-1:0] req_elem_value = '0;
   logic                      rsp_valid;
   logic [POS_W-1:0]          rsp_out_row;
   logic [POS_W-1:0]          rsp_out_col;
   logic signed [SUM_W-1:0]   rsp_sum_value;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = CSR_NUM_ROWS;
   logic [DIM_W-1:0]          csr_data = '0;

   // Shadow state of the engine
   logic signed [VALUE_W-1:0] left_mem [DIM*DIM];
   logic signed [VALUE_W-1:0] right_mem [DIM*DIM];
   bit                        left_written [DIM*DIM];
   bit                        right_written [DIM*DIM];
   logic [DIM_W-1:0]          rows_reg = DIM_RESET;
   logic [DIM_W-1:0]          inner_reg = DIM_RESET;
   logic [DIM_W-1:0]          cols_reg = DIM_RESET;

   product_entry_type pending_products [$];
   int             mismatch_count = 0;
   int             products_seen = 0;
   int             starts_sent = 0;
   int             loads_sent = 0;
   int             items_sent = 0;
   int             idle_pct = 0;

   matrix_multiply_engine u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .req_elem_value(req_elem_value),
      .rsp_valid(rsp_valid), .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_sum_value(rsp_sum_value), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic int clamp_dim(logic [DIM_W-1:0] v);
      return (v > DIM) ? DIM : int'(v);
   endfunction

   // Work out every product element a start item yields
   task automatic predict_products();
      int rows, mid, cols;
      longint acc;
      product_entry_type e;
      rows = clamp_dim(rows_reg);
      mid  = clamp_dim(inner_reg);
      cols = clamp_dim(cols_reg);
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            acc = 0;
            for (int k = 0; k < mid; k++)
               acc += longint'(left_mem[i*DIM+k]) * longint'(right_mem[k*DIM+j]);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            e.row  = i[POS_W-1:0];
            e.col  = j[POS_W-1:0];
            e.sum  = acc[SUM_W-1:0];
            e.last = (i == rows-1) && (j == cols-1);
            pending_products.insert(pending_products.size(), e);
         end
      end
   endtask

   // Send one item; hold start high until the engine takes it
   task automatic send_item(func_type f, int r, int c, logic [VALUE_W-1:0] v);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(4, 1);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          = 1'b1;
      req_func       = f;
      req_row_index  = r[POS_W-1:0];
      req_col_index  = c[POS_W-1:0];
      req_elem_value = v;
      do @(posedge clock); while (busy);
      items_sent++;
      case (f)
         FUNC_LOAD_LEFT: begin
            left_mem[r*DIM+c] = v;
            left_written[r*DIM+c] = 1'b1;
            loads_sent++;
         end
         FUNC_LOAD_RIGHT: begin
            right_mem[r*DIM+c] = v;
            right_written[r*DIM+c] = 1'b1;
            loads_sent++;
         end
         FUNC_START: begin
            predict_products();
            starts_sent++;
         end
         default: ;
      endcase
   endtask

   // Fill any entry the next multiply reads that was never loaded, then start
   task automatic run_multiply();
      int rows, mid, cols;
      rows = clamp_dim(rows_reg);
      mid  = clamp_dim(inner_reg);
      cols = clamp_dim(cols_reg);
      if (rows > 0 && cols > 0) begin
         for (int i = 0; i < rows; i++)
            for (int k = 0; k < mid; k++)
               if (!left_written[i*DIM+k])
                  send_item(FUNC_LOAD_LEFT, i, k, VALUE_W'($urandom));
         for (int k = 0; k < mid; k++)
            for (int j = 0; j < cols; j++)
               if (!right_written[k*DIM+j])
                  send_item(FUNC_LOAD_RIGHT, k, j, VALUE_W'($urandom));
      end
      send_item(FUNC_START, 0, 0, VALUE_W'($urandom));
   endtask

   // Wait for the engine to drain before touching a register
   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [DIM_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUM_ROWS:  rows_reg  = val;
         CSR_INNER_DIM: inner_reg = val;
         CSR_NUM_COLS:  cols_reg  = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_dims(int r, int k, int c);
      wait_quiet();
      write_reg(CSR_NUM_ROWS, r[DIM_W-1:0]);
      write_reg(CSR_INNER_DIM, k[DIM_W-1:0]);
      write_reg(CSR_NUM_COLS, c[DIM_W-1:0]);
   endtask

   // Compare each product element with the oldest prediction
   always @(posedge clock) begin
      product_entry_type e;
      if (!reset && rsp_valid) begin
         products_seen++;
         if (pending_products.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOW)
               $display("ERROR: unexpected product row %0d col %0d sum %0d last %0b",
                  rsp_out_row, rsp_out_col, rsp_sum_value, rsp_last);
         end else begin
            e = pending_products.pop_front();
            if (rsp_out_row !== e.row || rsp_out_col !== e.col ||
                rsp_sum_value !== e.sum || rsp_last !== e.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOW)
                  $display("ERROR: expected r%0d c%0d sum %0d last %0b, %s",
                     e.row, e.col, e.sum, e.last, "got:");
               if (mismatch_count <= MAX_SHOW)
                  $display("       actual   r%0d c%0d sum %0d last %0b",
                     rsp_out_row, rsp_out_col, rsp_sum_value, rsp_last);
            end
         end
      end
   end

   task automatic test_small_product();
      set_dims(1, 1, 1);
      send_item(FUNC_LOAD_LEFT, 0, 0, 16'h0100);
      send_item(FUNC_LOAD_RIGHT, 0, 0, 16'hFF80);
      send_item(FUNC_START, 0, 0, '0);
      send_item(FUNC_UNUSED, 7, 7, 16'hFFFF);
      run_multiply();
   endtask

   // Positive and negative overflow of the accumulator
   task automatic test_saturation();
      set_dims(1, 4, 2);
      for (int k = 0; k < 4; k++) begin
         send_item(FUNC_LOAD_LEFT, 0, k, 16'h8000);
         send_item(FUNC_LOAD_RIGHT, k, 0, 16'h8000);
         send_item(FUNC_LOAD_RIGHT, k, 1, 16'h7FFF);
      end
      run_multiply();
   endtask

   // Zero and oversized dimensions, unused register index, largest run
   task automatic test_dimension_edges();
      set_dims(0, 3, 2);
      run_multiply();
      set_dims(2, 0, 3);
      run_multiply();
      set_dims(3, 2, 0);
      run_multiply();
      wait_quiet();
      write_reg(CSR_NONE, 4'd1);
      set_dims(15, 1, 12);
      run_multiply();
      set_dims(1, 9, 2);
      run_multiply();
   endtask

   // Random runs until the running item count reaches the goal
   task automatic test_random_runs(int item_goal, int pct);
      int r, k, c, nload;
      idle_pct = pct;
      while (items_sent < item_goal) begin
         if ($urandom_range(9) == 0) begin
            r = $urandom_range(15); k = $urandom_range(2); c = $urandom_range(15);
         end else begin
            r = $urandom_range(4, 1); k = $urandom_range(4, 1); c = $urandom_range(4, 1);
         end
         set_dims(r, k, c);
         nload = $urandom_range(8);
         for (int n = 0; n < nload; n++) begin
            if ($urandom_range(7) == 0)
               send_item(FUNC_UNUSED, $urandom_range(7), $urandom_range(7),
                  VALUE_W'($urandom));
            else
               send_item($urandom_range(1) ? FUNC_LOAD_RIGHT : FUNC_LOAD_LEFT,
                  $urandom_range(7), $urandom_range(7), VALUE_W'($urandom));
         end
         run_multiply();
      end
      idle_pct = 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_small_product();
      test_saturation();
      test_dimension_edges();
      test_random_runs(95, 0);
      test_random_runs(130, 75);
      test_random_runs(160, 12);
      test_random_runs(185, 0);
      wait_quiet();
      repeat (DRAIN) @(posedge clock);
      if (pending_products.size() != 0) begin
         mismatch_count++;
         $display("ERROR: %0d product elements never arrived", pending_products.size());
      end
      $display("Sent %0d items: %0d loads and %0d multiplies; checked %0d product elements.",
         items_sent, loads_sent, starts_sent, products_seen);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #4000000;
      $display("ERROR: run timed out");
      $display("Test completed with failures");
      $finish;
   end

endmodule
